// ----- hw/rtl/lms_pkg.sv -----
// Shared types, register indexes, mode tables and helpers for the light mode sequencer.
// No dependencies; imported by light_mode_sequencer, lms_checker and the testbench.
package lms_pkg;

   // Register indexes on the csr port
   localparam logic [2:0] REG_SHORT_THR  = 3'd0;
   localparam logic [2:0] REG_MEDIUM_THR = 3'd1;
   localparam logic [2:0] REG_LOWBAT_THR = 3'd2;
   localparam logic [2:0] REG_TURBO_TMO  = 3'd3;
   localparam logic [2:0] REG_MODE_GROUP = 3'd4;
   localparam logic [2:0] REG_MEMORY_EN  = 3'd5;

   // Register reset values
   localparam logic [7:0] SHORT_THR_RESET  = 8'd190;
   localparam logic [7:0] MEDIUM_THR_RESET = 8'd94;
   localparam logic [7:0] LOWBAT_THR_RESET = 8'd125;
   localparam logic [7:0] TURBO_TMO_RESET  = 8'd90;

   // Opcodes
   localparam logic [1:0] OP_POWER_UP = 2'd0;
   localparam logic [1:0] OP_TICK     = 2'd1;
   localparam logic [1:0] OP_VOLTAGE  = 2'd2;

   // Mode kinds
   localparam logic [1:0] KIND_STEADY   = 2'd0;
   localparam logic [1:0] KIND_BIKE     = 2'd1;
   localparam logic [1:0] KIND_BATTCHK  = 2'd2;
   localparam logic [1:0] KIND_RAMPTEST = 2'd3;

   // Special level codes in the main table
   localparam logic [7:0] CODE_BIKE     = 8'd252;
   localparam logic [7:0] CODE_BATT     = 8'd254;
   localparam logic [7:0] CODE_RAMPTEST = 8'd251;
   localparam logic [7:0] LEVEL_TOP     = 8'd255;

   localparam logic [3:0] SOLID_G0      = 4'd7;
   localparam logic [3:0] SOLID_G1      = 4'd4;
   localparam logic [3:0] HIDDEN_COUNT  = 4'd4;
   localparam logic [3:0] LOW_RUN_LIMIT = 4'd8;
   localparam logic [4:0] FAST_LIMIT    = 5'h0f;
   localparam logic [3:0] LOWBAT_POS    = 4'd2;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] cap_reading;
      logic [7:0] battery_sample;
   } req_word_type;

   typedef struct packed {
      logic [3:0] mode_index;
      logic [1:0] mode_kind;
      logic [7:0] main_level;
      logic [7:0] alt_level;
      logic       fast_pwm;
      logic       config_entered;
      logic       shutdown;
      logic       save_request;
      logic [4:0] fast_press_count;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0] main_level;
      logic [7:0] alt_level;
      logic       fast_pwm;
   } mode_entry_type;

   // Group table lookup; positions past the group read as all zero.
   function automatic mode_entry_type mode_entry(input logic group, input logic [3:0] pos);
      mode_entry_type e;
      e = '0;
      if (!group) begin
         case (pos)
            4'd0:    e = '{8'd0,   8'd3,   1'b0};
            4'd1:    e = '{8'd0,   8'd20,  1'b1};
            4'd2:    e = '{8'd0,   8'd110, 1'b1};
            4'd3:    e = '{8'd7,   8'd255, 1'b1};
            4'd4:    e = '{8'd56,  8'd255, 1'b1};
            4'd5:    e = '{8'd137, 8'd255, 1'b1};
            4'd6:    e = '{8'd255, 8'd0,   1'b0};
            4'd7:    e = '{CODE_BIKE,     8'd0, 1'b0};
            4'd8:    e = '{CODE_BATT,     8'd0, 1'b0};
            4'd9:    e = '{CODE_RAMPTEST, 8'd0, 1'b0};
            4'd10:   e = '{LEVEL_TOP,     8'd0, 1'b0};
            default: e = '0;
         endcase
      end else begin
         case (pos)
            4'd0:    e = '{8'd0,   8'd20,  1'b1};
            4'd1:    e = '{8'd0,   8'd230, 1'b1};
            4'd2:    e = '{8'd90,  8'd255, 1'b1};
            4'd3:    e = '{8'd255, 8'd0,   1'b0};
            4'd4:    e = '{CODE_BIKE,     8'd0, 1'b0};
            4'd5:    e = '{CODE_BATT,     8'd0, 1'b0};
            4'd6:    e = '{CODE_RAMPTEST, 8'd0, 1'b0};
            4'd7:    e = '{LEVEL_TOP,     8'd0, 1'b0};
            default: e = '0;
         endcase
      end
      return e;
   endfunction

   function automatic logic [1:0] kind_of(input logic [7:0] lvl);
      logic [1:0] k;
      case (lvl)
         CODE_BIKE:     k = KIND_BIKE;
         CODE_BATT:     k = KIND_BATTCHK;
         CODE_RAMPTEST: k = KIND_RAMPTEST;
         default:       k = KIND_STEADY;
      endcase
      return k;
   endfunction

endpackage

// ----- hw/rtl/light_mode_sequencer.sv -----
// Light mode sequencer top level: input register, mode state update, result register.
// Depends on lms_pkg (types, register indexes, mode tables).
//
// Usage:
//   req channel (req_valid/req_ready/req_data) carries one event word: power-up
//   with an off-time cap reading, half-second tick, or battery sample.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) returns exactly one word per event:
//   mode index, kind, the two channel levels and PWM type, plus status flags.
//   csr port (csr_we/csr_index/csr_wdata) writes the six config registers,
//   one per cycle, no wait; write only while the block is idle.
// Timing:
//   rsp_valid rises once the word has passed the input register and then the
//   result register; a low rsp_ready can hold it in either. Throughput is one word
//   per cycle while rsp_ready stays high; the state update is two table lookups
//   (current and new position) plus a few narrow compares between the two registers.
// Reset:
//   Synchronous, active high. Registers return to their defaults, mode state
//   clears, both pipeline stages empty.
// Backpressure:
//   When rsp_ready is low the result holds; the input register still fills,
//   then req_ready drops until the result drains.
module light_mode_sequencer
   import lms_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   // Config registers
   logic [7:0] short_thr_ff, medium_thr_ff, lowbat_thr_ff, turbo_tmo_ff;
   logic       group_ff, mem_en_ff;

   // Mode state
   logic [3:0] pos_ff, pos_in;
   logic [4:0] fast_ff, fast_in;
   logic [7:0] tick_ff, tick_in;
   logic [3:0] run_ff, run_in;

   // Pipeline
   logic         s1_valid_ff;
   req_word_type s1_data_ff;
   logic         out_valid_ff;
   rsp_word_type out_data_ff, out_data_in;

   logic out_load;   // result register takes the stage-1 word
   logic s1_load;    // stage 1 takes a request word

   assign out_load  = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || out_load;
   assign s1_load   = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         short_thr_ff  <= SHORT_THR_RESET;
         medium_thr_ff <= MEDIUM_THR_RESET;
         lowbat_thr_ff <= LOWBAT_THR_RESET;
         turbo_tmo_ff  <= TURBO_TMO_RESET;
         group_ff      <= 1'b0;
         mem_en_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_SHORT_THR:  short_thr_ff  <= csr_wdata;
            REG_MEDIUM_THR: medium_thr_ff <= csr_wdata;
            REG_LOWBAT_THR: lowbat_thr_ff <= csr_wdata;
            REG_TURBO_TMO:  turbo_tmo_ff  <= csr_wdata;
            REG_MODE_GROUP: group_ff      <= csr_wdata[0];
            REG_MEMORY_EN:  mem_en_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- event processing ----------------
   logic [3:0]     solid, total;
   mode_entry_type cur_entry, new_entry;
   logic [1:0]     new_kind;
   logic           cfg, off, save;
   logic [3:0]     run_inc;

   assign solid = group_ff ? SOLID_G1 : SOLID_G0;
   assign total = solid + HIDDEN_COUNT;
   assign cur_entry = mode_entry(group_ff, pos_ff);

   always_comb begin
      pos_in  = pos_ff;
      fast_in = fast_ff;
      tick_in = tick_ff;
      run_in  = run_ff;
      cfg     = 1'b0;
      off     = 1'b0;
      save    = 1'b0;
      run_inc = run_ff + 4'd1;
      case (s1_data_ff.opcode)
         OP_POWER_UP: begin
            tick_in = '0;
            run_in  = '0;
            save    = 1'b1;
            if (s1_data_ff.cap_reading > short_thr_ff) begin
               // short press: advance, wrap past hidden modes
               fast_in = fast_ff + 5'd1;
               pos_in  = ((pos_ff + 4'd1) >= solid) ? 4'd0 : pos_ff + 4'd1;
            end else if (s1_data_ff.cap_reading > medium_thr_ff) begin
               // medium press: step back; from the first mode into the hidden ones
               fast_in = '0;
               if (pos_ff == solid)       pos_in = '0;
               else if (pos_ff != 4'd0)   pos_in = pos_ff - 4'd1;
               else                       pos_in = total - 4'd1;
            end else begin
               fast_in = '0;
               if (!mem_en_ff) pos_in = '0;
            end
            if (fast_in > FAST_LIMIT) begin
               cfg     = 1'b1;
               fast_in = '0;
               pos_in  = '0;
            end
         end
         OP_TICK: begin
            if (kind_of(cur_entry.main_level) == KIND_STEADY) begin
               tick_in = tick_ff + 8'd1;
               fast_in = '0;
               // turbo timeout steps down to the second-highest solid mode
               if (tick_in > turbo_tmo_ff && cur_entry.main_level == LEVEL_TOP) begin
                  pos_in = solid - 4'd2;
                  save   = 1'b1;
               end
            end
         end
         OP_VOLTAGE: begin
            run_in = (s1_data_ff.battery_sample < lowbat_thr_ff) ? run_inc : 4'd0;
            if (run_in >= LOW_RUN_LIMIT) begin
               if (pos_ff >= solid)     pos_in = LOWBAT_POS;
               else if (pos_ff != 4'd0) pos_in = pos_ff - 4'd1;
               else                     off    = 1'b1;
               save   = 1'b1;
               run_in = '0;
            end
         end
         default: ;   // unused opcode: report current mode, no change
      endcase

      new_entry = mode_entry(group_ff, pos_in);
      new_kind  = kind_of(new_entry.main_level);
      if (new_kind != KIND_STEADY || off) new_entry = '0;
      if (new_entry.main_level == 8'd0 && new_entry.alt_level == 8'd0)
         new_entry.fast_pwm = 1'b0;

      out_data_in.mode_index       = pos_in;
      out_data_in.mode_kind        = new_kind;
      out_data_in.main_level       = new_entry.main_level;
      out_data_in.alt_level        = new_entry.alt_level;
      out_data_in.fast_pwm         = new_entry.fast_pwm;
      out_data_in.config_entered   = cfg;
      out_data_in.shutdown         = off;
      out_data_in.save_request     = save;
      out_data_in.fast_press_count = fast_in;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
         fast_ff      <= '0;
         tick_ff      <= '0;
         run_ff       <= '0;
      end else begin
         if (s1_load)       s1_valid_ff <= 1'b1;
         else if (out_load) s1_valid_ff <= 1'b0;
         if (out_load)       out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
         if (out_load) begin
            pos_ff  <= pos_in;
            fast_ff <= fast_in;
            tick_ff <= tick_in;
            run_ff  <= run_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load)  s1_data_ff  <= req_data;
      if (out_load) out_data_ff <= out_data_in;
   end

   // ---------------- assertions ----------------
   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.config_entered) |->
         (rsp_data.mode_index == 4'd0 && rsp_data.fast_press_count == 5'd0 &&
          rsp_data.save_request))
      else $error("config entry did not clear mode and count");

   a_shutdown_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.shutdown) |->
         (rsp_data.main_level == 8'd0 && rsp_data.alt_level == 8'd0 &&
          rsp_data.mode_index == 4'd0 && rsp_data.save_request))
      else $error("shutdown word carries light output");

   a_fast_pwm_lit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.fast_pwm) |->
         (rsp_data.main_level != 8'd0 || rsp_data.alt_level != 8'd0))
      else $error("fast pwm with both levels zero");

   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      run_ff < LOW_RUN_LIMIT)
      else $error("low-sample run not cleared at limit");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !out_load |=> ($stable(pos_ff) && $stable(fast_ff) && $stable(tick_ff)))
      else $error("mode state changed without a word");

endmodule

// ----- tb/sv/lms_checker.sv -----
`timescale 1ns / 1ps
// Response checker for light_mode_sequencer: mirrors CSR writes, predicts one response
// word per accepted request word and compares response words in arrival order.
// Depends on lms_pkg for the word types, opcodes, register indexes and level codes.
module lms_checker
   import lms_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_word_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_word_type rsp_data,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [7:0]   csr_wdata,
   output int           mismatch_count,
   output int           words_pending
);

   typedef struct packed {
      logic [7:0] main_lvl;
      logic [7:0] alt_lvl;
      logic       fast;
   } level_row_type;

   // mirrored registers
   logic [7:0] thr_short, thr_medium, thr_lowbat, turbo_limit;
   logic       group_sel, memory_on;

   // mode state
   logic [3:0] mode_pos;
   logic [4:0] press_run;
   logic [7:0] tick_run;
   logic [3:0] low_run;

   rsp_word_type expected_words[$];

   // Level table: seven solid modes (group 0) or four (group 1), then the
   // hidden strobe / battery check / ramp test / turbo. Anything past reads zero.
   function automatic level_row_type table_row(input logic grp, input logic [3:0] pos);
      level_row_type r;
      r = '0;
      if (!grp) begin
         case (pos)
            4'd0:    r = '{8'd0,   8'd3,   1'b0};
            4'd1:    r = '{8'd0,   8'd20,  1'b1};
            4'd2:    r = '{8'd0,   8'd110, 1'b1};
            4'd3:    r = '{8'd7,   8'd255, 1'b1};
            4'd4:    r = '{8'd56,  8'd255, 1'b1};
            4'd5:    r = '{8'd137, 8'd255, 1'b1};
            4'd6:    r = '{8'd255, 8'd0,   1'b0};
            4'd7:    r = '{CODE_BIKE,     8'd0, 1'b0};
            4'd8:    r = '{CODE_BATT,     8'd0, 1'b0};
            4'd9:    r = '{CODE_RAMPTEST, 8'd0, 1'b0};
            4'd10:   r = '{LEVEL_TOP,     8'd0, 1'b0};
            default: r = '0;
         endcase
      end else begin
         case (pos)
            4'd0:    r = '{8'd0,   8'd20,  1'b1};
            4'd1:    r = '{8'd0,   8'd230, 1'b1};
            4'd2:    r = '{8'd90,  8'd255, 1'b1};
            4'd3:    r = '{8'd255, 8'd0,   1'b0};
            4'd4:    r = '{CODE_BIKE,     8'd0, 1'b0};
            4'd5:    r = '{CODE_BATT,     8'd0, 1'b0};
            4'd6:    r = '{CODE_RAMPTEST, 8'd0, 1'b0};
            4'd7:    r = '{LEVEL_TOP,     8'd0, 1'b0};
            default: r = '0;
         endcase
      end
      return r;
   endfunction

   function automatic logic [1:0] level_kind(input logic [7:0] lvl);
      if (lvl == CODE_BIKE) return KIND_BIKE;
      if (lvl == CODE_BATT) return KIND_BATTCHK;
      if (lvl == CODE_RAMPTEST) return KIND_RAMPTEST;
      return KIND_STEADY;
   endfunction

   // Advance the mode state by one event and build the response word it yields.
   task automatic predict_mode_word(input req_word_type w, output rsp_word_type r);
      logic [3:0]    solid, total;
      level_row_type row;
      logic [1:0]    kind;
      logic          cfg_hit, off, save;
      solid   = group_sel ? SOLID_G1 : SOLID_G0;
      total   = solid + HIDDEN_COUNT;
      cfg_hit = 1'b0;
      off     = 1'b0;
      save    = 1'b0;
      case (w.opcode)
         OP_POWER_UP: begin
            tick_run = '0;
            low_run  = '0;
            if (w.cap_reading > thr_short) begin
               press_run = press_run + 5'd1;
               mode_pos  = mode_pos + 4'd1;
               if (mode_pos >= solid) mode_pos = '0;
            end else if (w.cap_reading > thr_medium) begin
               press_run = '0;
               if (mode_pos == solid) mode_pos = '0;
               else if (mode_pos != '0) mode_pos = mode_pos - 4'd1;
               else mode_pos = total - 4'd1;
            end else begin
               press_run = '0;
               if (!memory_on) mode_pos = '0;
            end
            save = 1'b1;
            if (press_run > FAST_LIMIT) begin
               cfg_hit   = 1'b1;
               press_run = '0;
               mode_pos  = '0;
            end
         end
         OP_TICK: begin
            row = table_row(group_sel, mode_pos);
            if (level_kind(row.main_lvl) == KIND_STEADY) begin
               tick_run = tick_run + 8'd1;
               if (tick_run > turbo_limit && row.main_lvl == LEVEL_TOP) begin
                  mode_pos = solid - 4'd2;
                  save     = 1'b1;
               end
               press_run = '0;
            end
         end
         OP_VOLTAGE: begin
            if (w.battery_sample < thr_lowbat) low_run = low_run + 4'd1;
            else low_run = '0;
            if (low_run >= LOW_RUN_LIMIT) begin
               if (mode_pos >= solid) mode_pos = LOWBAT_POS;
               else if (mode_pos != '0) mode_pos = mode_pos - 4'd1;
               else off = 1'b1;
               save    = 1'b1;
               low_run = '0;
            end
         end
         default: ;
      endcase

      row  = table_row(group_sel, mode_pos);
      kind = level_kind(row.main_lvl);
      if (kind != KIND_STEADY || off) row = '0;
      if (row.main_lvl == '0 && row.alt_lvl == '0) row.fast = 1'b0;

      r                  = '0;
      r.mode_index       = mode_pos;
      r.mode_kind        = kind;
      r.main_level       = row.main_lvl;
      r.alt_level        = row.alt_lvl;
      r.fast_pwm         = row.fast;
      r.config_entered   = cfg_hit;
      r.shutdown         = off;
      r.save_request     = save;
      r.fast_press_count = press_run;
   endtask

   always @(posedge clock) begin : watch
      rsp_word_type want;
      rsp_word_type next_word;
      string        diffs;
      if (reset) begin
         thr_short   = SHORT_THR_RESET;
         thr_medium  = MEDIUM_THR_RESET;
         thr_lowbat  = LOWBAT_THR_RESET;
         turbo_limit = TURBO_TMO_RESET;
         group_sel   = 1'b0;
         memory_on   = 1'b0;
         mode_pos    = '0;
         press_run   = '0;
         tick_run    = '0;
         low_run     = '0;
         expected_words.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_SHORT_THR:  thr_short   = csr_wdata;
               REG_MEDIUM_THR: thr_medium  = csr_wdata;
               REG_LOWBAT_THR: thr_lowbat  = csr_wdata;
               REG_TURBO_TMO:  turbo_limit = csr_wdata;
               REG_MODE_GROUP: group_sel   = csr_wdata[0];
               REG_MEMORY_EN:  memory_on   = csr_wdata[0];
               default: ;
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response word %h with none expected", $time, rsp_data);
            end else begin
               want = expected_words.pop_front();
               if (rsp_data !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     diffs = "";
                     if (rsp_data.mode_index !== want.mode_index)
                        diffs = {diffs, $sformatf(" mode_index exp %0d got %0d",
                                                  want.mode_index, rsp_data.mode_index)};
                     if (rsp_data.mode_kind !== want.mode_kind)
                        diffs = {diffs, $sformatf(" mode_kind exp %0d got %0d",
                                                  want.mode_kind, rsp_data.mode_kind)};
                     if (rsp_data.main_level !== want.main_level)
                        diffs = {diffs, $sformatf(" main_level exp %0d got %0d",
                                                  want.main_level, rsp_data.main_level)};
                     if (rsp_data.alt_level !== want.alt_level)
                        diffs = {diffs, $sformatf(" alt_level exp %0d got %0d",
                                                  want.alt_level, rsp_data.alt_level)};
                     if (rsp_data.fast_pwm !== want.fast_pwm)
                        diffs = {diffs, $sformatf(" fast_pwm exp %b got %b",
                                                  want.fast_pwm, rsp_data.fast_pwm)};
                     if (rsp_data.config_entered !== want.config_entered)
                        diffs = {diffs, $sformatf(" config_entered exp %b got %b",
                                                  want.config_entered, rsp_data.config_entered)};
                     if (rsp_data.shutdown !== want.shutdown)
                        diffs = {diffs, $sformatf(" shutdown exp %b got %b",
                                                  want.shutdown, rsp_data.shutdown)};
                     if (rsp_data.save_request !== want.save_request)
                        diffs = {diffs, $sformatf(" save_request exp %b got %b",
                                                  want.save_request, rsp_data.save_request)};
                     if (rsp_data.fast_press_count !== want.fast_press_count)
                        diffs = {diffs, $sformatf(" fast_press_count exp %0d got %0d",
                                                  want.fast_press_count,
                                                  rsp_data.fast_press_count)};
                     $display("%0t: response mismatch:%s", $time, diffs);
                  end
               end
            end
         end

         if (req_valid && req_ready) begin
            predict_mode_word(req_data, next_word);
            expected_words.push_back(next_word);
         end
      end
      words_pending = expected_words.size();
   end

endmodule

// ----- tb/sv/tb_light_mode_sequencer.sv -----
`timescale 1ns / 1ps
// Top of the light_mode_sequencer testbench: clock, reset, CSR programming, request
// words in bursts with gaps, response backpressure and the final verdict.
// Depends on lms_pkg, light_mode_sequencer and lms_checker (prediction and compare).
module tb_light_mode_sequencer;
   import lms_pkg::*;

   // opcode the block has no use for; it must report the mode and change nothing
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int NUM_PHASES   = 9;
   localparam int WORDS_TOTAL  = 1450;
   localparam int DRAIN_CYCLES = 6;   // pipeline is two deep, a few spare cycles

   typedef enum int {SINK_READY, SINK_RANDOM, SINK_PATTERN} sink_mode_type;
   typedef enum int {PRESS_SHORT, PRESS_MEDIUM, PRESS_LONG} press_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_we    = 1'b0;
   logic [2:0]   csr_index = REG_SHORT_THR;
   logic [7:0]   csr_wdata = '0;

   int mismatch_count;
   int words_pending;

   // What the stimulus believes is programmed; used only to aim cap and
   // battery values at the intended press class / battery state.
   int cfg_short = int'(SHORT_THR_RESET);
   int cfg_med   = int'(MEDIUM_THR_RESET);
   int cfg_low   = int'(LOWBAT_THR_RESET);
   int cfg_tmo   = int'(TURBO_TMO_RESET);
   int cfg_grp   = 0;
   int cfg_mem   = 0;

   int            burst_left    = 0;
   bit            gaps_on       = 1'b1;
   int            words_sent    = 0;
   sink_mode_type sink_mode     = SINK_READY;
   logic [15:0]   stall_pattern = 16'hE6B1;

   light_mode_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lms_checker chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Response side: always ready, random stalls, or a fixed rotating pattern.
   always @(posedge clock) begin
      case (sink_mode)
         SINK_READY:  rsp_ready <= 1'b1;
         SINK_RANDOM: rsp_ready <= ($urandom_range(0, 99) < 65);
         default: begin
            stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
            rsp_ready     <= stall_pattern[15];
         end
      endcase
   end

   // Hang guard: far beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("[light_mode_sequencer] ERROR");
      $finish;
   end

   // Cap reading that lands in the requested press class under the current
   // thresholds; falls back to anything when the class is empty. Boundaries
   // get picked now and then.
   function automatic logic [7:0] cap_for(input press_type press);
      int lo, hi, c;
      lo = 0;
      hi = 255;
      case (press)
         PRESS_SHORT: begin
            if (cfg_short < 255) lo = cfg_short + 1;
         end
         PRESS_MEDIUM: begin
            if (cfg_med < cfg_short) begin
               lo = cfg_med + 1;
               hi = cfg_short;
            end
         end
         default: hi = cfg_med;
      endcase
      case ($urandom_range(0, 9))
         0:       c = lo;
         1:       c = hi;
         default: c = $urandom_range(lo, hi);
      endcase
      return c[7:0];
   endfunction

   // Battery sample below (low) or at/above the low-battery threshold.
   function automatic logic [7:0] batt_for(input bit low);
      int lo, hi, c;
      lo = 0;
      hi = 255;
      if (low) begin
         if (cfg_low > 0) hi = cfg_low - 1;
      end else begin
         lo = cfg_low;
      end
      case ($urandom_range(0, 9))
         0:       c = lo;
         1:       c = hi;
         default: c = $urandom_range(lo, hi);
      endcase
      return c[7:0];
   endfunction

   // Present one request word. Bursts of random length with idle gaps between
   // them; valid stays up until the word is taken. req_ready is looked at on
   // the falling edge, where everything driven at the rising edge has settled.
   task automatic send_word(input logic [1:0] op, input logic [7:0] cap,
                            input logic [7:0] batt);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = (!gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(posedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(posedge clock);
         end
      end
      burst_left--;
      @(posedge clock);
      req_valid <= 1'b1;
      req_data  <= '{opcode: op, cap_reading: cap, battery_sample: batt};
      words_sent++;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
   endtask

   // Drop valid and hold off until every predicted response has come back,
   // then let the pipeline settle.
   task automatic wait_drained();
      @(posedge clock);
      req_valid <= 1'b0;
      @(negedge clock);
      while (words_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[7:0];
   endtask

   initial begin : stimulus
      int phase, run, n, i;
      bit held;
      held = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part, reset register values (group 0, memory off) ----
      // short presses, including one reading just above the threshold
      send_word(OP_POWER_UP, 8'd255, 8'd0);
      send_word(OP_POWER_UP, 8'd191, 8'd255);
      // exactly at the short threshold counts as medium: step back
      send_word(OP_POWER_UP, 8'd190, 8'd0);
      send_word(OP_POWER_UP, 8'd95, 8'd0);
      // at the medium threshold is a long press; memory off sends us to mode 0
      send_word(OP_POWER_UP, 8'd94, 8'd0);
      send_word(OP_POWER_UP, 8'd0, 8'd0);
      // medium from mode 0 wraps into the hidden modes: turbo, ramp, battcheck, strobe
      send_word(OP_POWER_UP, 8'd95, 8'd0);
      send_word(OP_POWER_UP, 8'd95, 8'd0);
      send_word(OP_POWER_UP, 8'd95, 8'd0);
      send_word(OP_POWER_UP, 8'd95, 8'd0);
      // tick in a blinky mode leaves the counters alone
      send_word(OP_TICK, 8'd255, 8'd255);
      // medium at the first hidden mode goes back to mode 0
      send_word(OP_POWER_UP, 8'd95, 8'd0);
      // sample at the threshold is not low; then eight low ones at mode 0 shut down
      send_word(OP_VOLTAGE, 8'd0, 8'd125);
      for (i = 0; i < 7; i++) send_word(OP_VOLTAGE, 8'd255, 8'd0);
      send_word(OP_VOLTAGE, 8'd0, 8'd124);
      // unused opcode, then life goes on after the shutdown
      send_word(OP_UNUSED, 8'hff, 8'hff);
      send_word(OP_TICK, 8'd0, 8'd0);

      // ---- random part, one register setting per phase ----
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            wait_drained();
            case (phase)
               1: begin
                  // no short press possible, everything above 0 is medium
                  cfg_short = 255; cfg_med = 0; cfg_low = 255; cfg_tmo = 0;
                  cfg_grp = 1; cfg_mem = 1;
               end
               2: begin
                  // everything above 0 is short, battery never low, turbo never times out
                  cfg_short = 0; cfg_med = 255; cfg_low = 0; cfg_tmo = 255;
                  cfg_grp = 0; cfg_mem = 0;
               end
               default: begin
                  cfg_short = $urandom_range(120, 250);
                  cfg_med   = $urandom_range(10, cfg_short - 1);
                  cfg_low   = $urandom_range(1, 255);
                  cfg_tmo   = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(0, 30);
                  cfg_grp   = $urandom_range(0, 1);
                  cfg_mem   = $urandom_range(0, 1);
               end
            endcase
            write_reg(REG_SHORT_THR,  cfg_short);
            write_reg(REG_MEDIUM_THR, cfg_med);
            write_reg(REG_LOWBAT_THR, cfg_low);
            write_reg(REG_TURBO_TMO,  cfg_tmo);
            write_reg(REG_MODE_GROUP, cfg_grp);
            write_reg(REG_MEMORY_EN,  cfg_mem);
            @(posedge clock);
            csr_we <= 1'b0;
         end

         sink_mode = sink_mode_type'(phase % 3);
         gaps_on   = (phase % 4 != 1);

         while (words_sent < WORDS_TOTAL * (phase + 1) / NUM_PHASES) begin
            // once mid-run: stop feeding until the block has emptied
            if (phase == 3 && !held && words_sent > WORDS_TOTAL * 7 / (2 * NUM_PHASES)) begin
               wait_drained();
               held = 1'b1;
            end
            run = $urandom_range(0, 99);
            if (run < 20) begin
               // fast presses; long runs go past fifteen into config entry
               n = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 18) : $urandom_range(1, 6);
               repeat (n)
                  send_word(OP_POWER_UP, cap_for(PRESS_SHORT), 8'($urandom_range(0, 255)));
            end else if (run < 34) begin
               repeat ($urandom_range(1, 4))
                  send_word(OP_POWER_UP, cap_for(PRESS_MEDIUM), 8'($urandom_range(0, 255)));
            end else if (run < 44) begin
               repeat ($urandom_range(1, 2))
                  send_word(OP_POWER_UP, cap_for(PRESS_LONG), 8'($urandom_range(0, 255)));
            end else if (run < 64) begin
               // tick runs: short, past the turbo timeout, or long enough to wrap
               case ($urandom_range(0, 14))
                  0:       n = $urandom_range(257, 265);
                  1, 2, 3: n = cfg_tmo + $urandom_range(1, 8);
                  default: n = $urandom_range(1, 12);
               endcase
               repeat (n)
                  send_word(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else if (run < 79) begin
               if ($urandom_range(0, 1)) begin
                  // low-battery run, sometimes broken by a good sample
                  n = $urandom_range(8, 12);
                  for (i = 0; i < n; i++)
                     send_word(OP_VOLTAGE, 8'($urandom_range(0, 255)),
                               batt_for(!(i == 4 && $urandom_range(0, 3) == 0)));
               end else begin
                  repeat ($urandom_range(1, 4))
                     send_word(OP_VOLTAGE, 8'($urandom_range(0, 255)),
                               batt_for(1'($urandom_range(0, 1))));
               end
            end else if (run < 87) begin
               // head for turbo and sit there past the timeout
               send_word(OP_POWER_UP, cap_for(PRESS_LONG), 8'($urandom_range(0, 255)));
               send_word(OP_POWER_UP, cap_for(PRESS_MEDIUM), 8'($urandom_range(0, 255)));
               repeat (cfg_tmo + 2)
                  send_word(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else begin
               // noise: any opcode, any field values
               repeat ($urandom_range(1, 4))
                  send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)));
            end
         end

         // Park in the top hidden mode so a switch to the smaller group starts
         // from a position outside it.
         send_word(OP_POWER_UP, cap_for(PRESS_LONG), 8'd0);
         send_word(OP_POWER_UP, cap_for(PRESS_MEDIUM), 8'd0);
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("[light_mode_sequencer] OK");
      end else begin
         $display("[light_mode_sequencer] ERROR");
      end
      $finish;
   end

endmodule
